### rtl/rlcs_pkg.sv
// Shared types and constants for the RGB LED chain serializer.
// Used by every module of the block; depends on nothing.
package rlcs_pkg;

	// Fixed widths of the item fields.
	localparam int IDX_W   = 7;
	localparam int COLOR_W = 8;
	localparam int RGB_W   = 3 * COLOR_W;
	localparam int GAP_W   = 12;
	localparam int BIT_W   = 5;
	localparam int UNIT_W  = 3;

	// Waveform timing, in time units.
	localparam logic [UNIT_W-1:0] UNITS_LAST      = 3'd4;
	localparam logic [UNIT_W-1:0] HIGH_UNITS_ONE  = 3'd4;
	localparam logic [UNIT_W-1:0] HIGH_UNITS_ZERO = 3'd1;
	localparam logic [BIT_W-1:0]  BIT_LAST        = 5'd23;
	localparam logic [GAP_W-1:0]  GAP_RESET_VALUE = 12'd1200;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_SET     = 3'd1,
		OP_FILL    = 3'd2,
		OP_ALL     = 3'd3,
		OP_REFRESH = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_LOAD,
		ST_LATCH,
		ST_SEND,
		ST_GAP
	} state_t;

	// Write controls from the sequencer to the pixel buffer.
	typedef struct packed {
		logic wr;
		logic clear_all;
	} buf_cmd_t;

	// One result beat.
	typedef struct packed {
		logic level;
		logic busy;
		logic rej;
	} result_t;

endpackage

### rtl/rlcs_pixel_buf.sv
// Pixel buffer: one row of green, red, blue per pixel, with a valid bit per row.
// Rows that are not valid read as the last set-all value. Depends on rlcs_pkg.
module rlcs_pixel_buf #(
	parameter int MAX_PIXELS = 64,
	parameter int AW = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlcs_pkg::buf_cmd_t            cmd,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [rlcs_pkg::RGB_W-1:0]    wr_data,
	input  logic [rlcs_pkg::COLOR_W-1:0]  clear_byte,
	input  logic [AW-1:0]                 rd_addr,
	output logic [rlcs_pkg::RGB_W-1:0]    rd_data
);
	import rlcs_pkg::*;

	logic [RGB_W-1:0]   mem [MAX_PIXELS];
	logic [MAX_PIXELS-1:0] row_valid_q;
	logic [COLOR_W-1:0] default_byte_q;
	logic [RGB_W-1:0]   rd_data_q;

	// Row storage, written one row per cycle.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Valid bits and the background value; a set-all drops every row back to it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q    <= '0;
			default_byte_q <= '0;
		end else if (cmd.clear_all) begin
			row_valid_q    <= '0;
			default_byte_q <= clear_byte;
		end else if (cmd.wr) begin
			row_valid_q[wr_addr] <= 1'b1;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (row_valid_q[rd_addr]) begin
			rd_data_q <= mem[rd_addr];
		end else begin
			rd_data_q <= {3{default_byte_q}};
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/rlcs_ctrl.sv
// Sequencer of the serializer: command decode, fill sweep, bit timing and latch gap.
// One row counter is shared by the fill sweep and the refresh. Depends on rlcs_pkg.
module rlcs_ctrl #(
	parameter int MAX_PIXELS = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          slot_free,
	input  logic [2:0]                    opcode,
	input  logic [rlcs_pkg::IDX_W-1:0]    pixel_index,
	input  logic [rlcs_pkg::COLOR_W-1:0]  red,
	input  logic [rlcs_pkg::COLOR_W-1:0]  green,
	input  logic [rlcs_pkg::COLOR_W-1:0]  blue,
	input  logic [rlcs_pkg::GAP_W-1:0]    reset_units,
	input  logic [rlcs_pkg::RGB_W-1:0]    rd_data,
	output logic                          in_ready,
	output logic                          accept,
	output rlcs_pkg::result_t             result,
	output rlcs_pkg::buf_cmd_t            buf_cmd,
	output logic [AW-1:0]                 wr_addr,
	output logic [rlcs_pkg::RGB_W-1:0]    wr_data,
	output logic [AW-1:0]                 rd_addr
);
	import rlcs_pkg::*;

	state_t            state_q, state_d;
	logic [CW-1:0]     row_q, count_q, row_nxt;
	logic [UNIT_W-1:0] unit_q;
	logic [BIT_W-1:0]  bit_q;
	logic [RGB_W-1:0]  shift_q;
	logic [RGB_W-1:0]  fill_rgb_q;
	logic [GAP_W-1:0]  gap_q;

	logic is_tick, busy_now, level_now, n_ok, n_zero, cmd_ok, gap_nz;
	logic idle_cmd, tick_send, bit_done, pixel_done, last_pixel, start_send;

	// Item decode.
	assign is_tick  = (opcode == OP_TICK);
	assign n_ok     = (32'(pixel_index) <= MAX_PIXELS);
	assign n_zero   = (pixel_index == '0);
	assign gap_nz   = (reset_units != '0);
	assign busy_now = state_q inside {ST_LOAD, ST_LATCH, ST_SEND, ST_GAP};
	assign idle_cmd = accept && !is_tick && (state_q == ST_IDLE) && cmd_ok;

	always_comb begin
		case (opcode_t'(opcode))
			OP_SET:     cmd_ok = n_ok && !n_zero;
			OP_FILL:    cmd_ok = n_ok;
			OP_ALL:     cmd_ok = 1'b1;
			OP_REFRESH: cmd_ok = n_ok;
			default:    cmd_ok = 1'b0;
		endcase
	end

	// Bit timing: level of the current unit and the end of bit and pixel.
	assign level_now  = (state_q == ST_SEND) &&
		(unit_q < (shift_q[RGB_W-1] ? HIGH_UNITS_ONE : HIGH_UNITS_ZERO));
	assign row_nxt    = row_q + CW'(1);
	assign tick_send  = accept && is_tick && (state_q == ST_SEND);
	assign bit_done   = tick_send && (unit_q == UNITS_LAST);
	assign pixel_done = bit_done && (bit_q == BIT_LAST);
	assign last_pixel = (row_nxt == count_q);
	assign start_send = idle_cmd && (opcode == OP_REFRESH) && !n_zero;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (idle_cmd && (opcode == OP_FILL) && !n_zero) begin
					state_d = ST_FILL;
				end else if (idle_cmd && (opcode == OP_REFRESH)) begin
					if (!n_zero) begin
						state_d = ST_LOAD;
					end else if (gap_nz) begin
						state_d = ST_GAP;
					end
				end
			end
			ST_FILL: begin
				if (last_pixel) begin
					state_d = ST_IDLE;
				end
			end
			ST_LOAD:  state_d = ST_LATCH;
			ST_LATCH: state_d = ST_SEND;
			ST_SEND: begin
				if (pixel_done) begin
					if (!last_pixel) begin
						state_d = ST_LOAD;
					end else if (gap_nz) begin
						state_d = ST_GAP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_GAP: begin
				if (accept && is_tick && (gap_q == GAP_W'(1))) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake, result and buffer controls.
	always_comb begin
		in_ready = slot_free && (state_q inside {ST_IDLE, ST_SEND, ST_GAP});
		accept   = in_valid && in_ready;

		result.level = start_send || level_now;
		result.busy  = busy_now ||
			(idle_cmd && (opcode == OP_REFRESH) && (!n_zero || gap_nz));
		result.rej   = !is_tick && (busy_now || !cmd_ok);

		buf_cmd.wr        = (state_q == ST_FILL) || (idle_cmd && (opcode == OP_SET));
		buf_cmd.clear_all = idle_cmd && (opcode == OP_ALL);
		if (state_q == ST_FILL) begin
			wr_addr = row_q[AW-1:0];
			wr_data = fill_rgb_q;
		end else begin
			wr_addr = AW'(pixel_index - IDX_W'(1));
			wr_data = {green, red, blue};
		end
		rd_addr = row_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			count_q <= '0;
			unit_q  <= '0;
			bit_q   <= '0;
			gap_q   <= '0;
		end else begin
			state_q <= state_d;

			// Shared row counter: fill sweep and refresh walk over the same rows.
			if (idle_cmd && ((opcode == OP_FILL) || (opcode == OP_REFRESH))) begin
				row_q   <= '0;
				count_q <= CW'(pixel_index);
			end else if ((state_q == ST_FILL) || pixel_done) begin
				row_q <= row_nxt;
			end

			// Unit and bit position within the current pixel.
			if (state_q == ST_LATCH) begin
				unit_q <= '0;
				bit_q  <= '0;
			end else if (bit_done) begin
				unit_q <= '0;
				bit_q  <= bit_q + BIT_W'(1);
			end else if (tick_send) begin
				unit_q <= unit_q + UNIT_W'(1);
			end

			// Latch gap counter.
			if ((idle_cmd && (opcode == OP_REFRESH) && n_zero) ||
					(pixel_done && last_pixel)) begin
				gap_q <= reset_units;
			end else if (accept && is_tick && (state_q == ST_GAP)) begin
				gap_q <= gap_q - GAP_W'(1);
			end
		end
	end

	// Pixel shift register and held fill color.
	always_ff @(posedge clk) begin
		if (state_q == ST_LATCH) begin
			shift_q <= rd_data;
		end else if (bit_done) begin
			shift_q <= {shift_q[RGB_W-2:0], 1'b0};
		end
		if (idle_cmd && (opcode == OP_FILL)) begin
			fill_rgb_q <= {green, red, blue};
		end
	end

endmodule

### rtl/rgb_led_chain_serializer_unit.sv
// Top level of the RGB LED chain serializer: latch-gap register, result register,
// sequencer and pixel buffer. Depends on rlcs_pkg, rlcs_ctrl and rlcs_pixel_buf.
//
//   Channel  Signals                                            Direction
//   input    in_valid/in_ready, opcode, pixel_index, red,       into block
//            green, blue, fill_byte
//   result   out_valid/out_ready, line_level, busy_res,         out of block
//            rejected
//   config   cfg_we, cfg_wdata (reset_units)                    into block
//
// Every item gives one result beat, held in an output register while the next
// item is taken. A fill of N pixels writes N rows, one buffer row per cycle.
// Each pixel of a refresh (the first included) fetches its row from the buffer
// port through the load and latch states, during which no beat is taken.
// After reset the buffer reads as zero at once through its row valid bits.
// A stalled result only holds off the next input beat.
module rgb_led_chain_serializer_unit #(
	parameter int MAX_PIXELS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    opcode,
	input  logic [rlcs_pkg::IDX_W-1:0]    pixel_index,
	input  logic [rlcs_pkg::COLOR_W-1:0]  red,
	input  logic [rlcs_pkg::COLOR_W-1:0]  green,
	input  logic [rlcs_pkg::COLOR_W-1:0]  blue,
	input  logic [rlcs_pkg::COLOR_W-1:0]  fill_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          line_level,
	output logic                          busy_res,
	output logic                          rejected,
	input  logic                          cfg_we,
	input  logic [rlcs_pkg::GAP_W-1:0]    cfg_wdata
);
	import rlcs_pkg::*;

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW = $clog2(MAX_PIXELS + 1);

	logic [GAP_W-1:0] reset_units_q;
	logic             out_valid_q;
	result_t          result_q, result;
	logic             accept, slot_free;
	buf_cmd_t         buf_cmd;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [RGB_W-1:0] wr_data, rd_data;

	// Latch gap length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_units_q <= GAP_RESET_VALUE;
		end else if (cfg_we) begin
			reset_units_q <= cfg_wdata;
		end
	end

	// Output register: filled by every accepted input beat.
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_level = result_q.level;
	assign busy_res   = result_q.busy;
	assign rejected   = result_q.rej;

	rlcs_ctrl #(
		.MAX_PIXELS (MAX_PIXELS),
		.AW         (AW),
		.CW         (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.slot_free   (slot_free),
		.opcode      (opcode),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.reset_units (reset_units_q),
		.rd_data     (rd_data),
		.in_ready    (in_ready),
		.accept      (accept),
		.result      (result),
		.buf_cmd     (buf_cmd),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr)
	);

	rlcs_pixel_buf #(
		.MAX_PIXELS (MAX_PIXELS),
		.AW         (AW)
	) u_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (buf_cmd),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.clear_byte (fill_byte),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

endmodule
